[hw/rtl/framebuffer_clipped_draw_macros.svh]
// assertion helpers used by the frame store controller
`ifndef FRAMEBUFFER_CLIPPED_DRAW_MACROS_SVH
`define FRAMEBUFFER_CLIPPED_DRAW_MACROS_SVH

// antecedent in one cycle implies consequent in the next
`define FCD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcd next-cycle check failed");

// antecedent implies consequent in the same cycle
`define FCD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcd same-cycle check failed");

`endif

[hw/rtl/fcd_pkg.sv]
package fcd_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int CRD_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = 17;
    localparam int COLOR_W = 16;
    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_PIXEL = 3'd0;
    localparam logic [OP_W-1:0] OP_HSPAN = 3'd1;
    localparam logic [OP_W-1:0] OP_VSPAN = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clip;
        logic addr;
        logic write;
        logic rd_req;
        logic rd_cap;
    } fcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic remain_zero;
    } fcd_stat_t;

endpackage

[hw/rtl/fcd_ram.sv]
module fcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fcd_ctrl.sv]
`include "framebuffer_clipped_draw_macros.svh"

module fcd_ctrl
    import fcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  fcd_stat_t stat,
    output fcd_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLIP  = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_RDREQ = 3'd4;
    localparam logic [2:0] ST_RDCAP = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                cmd.clip = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.addr = 1'b1;
                state_next = stat.is_read ? ST_RDREQ : ST_RUN;
            end
            ST_RUN:
            begin
                if (stat.remain_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.write = 1'b1;
                end
            end
            ST_RDREQ:
            begin
                cmd.rd_req = 1'b1;
                state_next = ST_RDCAP;
            end
            ST_RDCAP:
            begin
                cmd.rd_cap = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    `FCD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `FCD_ASSERT_NEXT(a_done_once, done, !done && !busy)
    `FCD_ASSERT_SAME(a_write_counted, cmd.write, !stat.remain_zero && !stat.is_read)
    `FCD_ASSERT_NEXT(a_read_no_write, cmd.rd_req, !cmd.write)

endmodule

[hw/rtl/fcd_dp.sv]
module fcd_dp
    import fcd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  fcd_cmd_t                 cmd,
    output fcd_stat_t                stat,
    input  logic [OP_W-1:0]          opcode,
    input  logic signed [15:0]       pos_x,
    input  logic signed [15:0]       pos_y,
    input  logic signed [15:0]       span_length,
    input  logic [COLOR_W-1:0]       color,
    output logic [COLOR_W-1:0]       read_color,
    output logic [CNT_W-1:0]         written_count
);

    localparam logic signed [17:0] W18 = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] H18 = 18'(SCREEN_HEIGHT);

    logic [OP_W-1:0]        op_reg;
    logic signed [15:0]     x_reg;
    logic signed [15:0]     y_reg;
    logic signed [15:0]     len_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic [CRD_W-1:0]       first_reg;
    logic [CRD_W-1:0]       line_reg;
    logic [CNT_W-1:0]       wc_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic                   onscr_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [ADDR_W-1:0]      stride_reg;
    logic [COLOR_W-1:0]     rd_reg;
    logic [COLOR_W-1:0]     ram_rdata;

    logic signed [17:0] c_start;
    logic signed [17:0] c_len;
    logic signed [17:0] c_lim;
    logic signed [17:0] c_other;
    logic signed [17:0] c_olim;
    logic signed [17:0] c_end;
    logic signed [17:0] c_lo;
    logic signed [17:0] c_hi;
    logic signed [17:0] c_diff;
    logic               line_ok;
    logic [CNT_W-1:0]   clip_count;
    logic [CRD_W-1:0]   first_next;
    logic [CRD_W-1:0]   line_next;
    logic [ADDR_W-1:0]  base_addr;

    // pixel and read are a one-pixel horizontal span
    always_comb
    begin
        c_start = 18'(x_reg);
        c_len   = 18'sd1;
        c_lim   = W18;
        c_other = 18'(y_reg);
        c_olim  = H18;
        case (op_reg)
            OP_PIXEL, OP_READ:
            begin
                c_len = 18'sd1;
            end
            OP_HSPAN:
            begin
                c_len = 18'(len_reg);
            end
            OP_VSPAN:
            begin
                c_start = 18'(y_reg);
                c_len   = 18'(len_reg);
                c_lim   = H18;
                c_other = 18'(x_reg);
                c_olim  = W18;
            end
            default:
            begin
                c_len = 18'sd0;
            end
        endcase
    end

    assign c_end   = c_start + c_len;
    assign c_lo    = (c_start < 18'sd0) ? 18'sd0 : c_start;
    assign c_hi    = (c_end > c_lim) ? c_lim : c_end;
    assign c_diff  = c_hi - c_lo;
    assign line_ok = (c_other >= 18'sd0) && (c_other < c_olim);

    always_comb
    begin
        clip_count = '0;
        first_next = c_lo[CRD_W-1:0];
        line_next  = c_other[CRD_W-1:0];
        if (op_reg == OP_FILL)
        begin
            clip_count = CNT_W'(PIXEL_COUNT);
            first_next = '0;
            line_next  = '0;
        end
        else if (line_ok && (c_len > 18'sd0) && (c_diff > 18'sd0))
        begin
            clip_count = c_diff[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (op_reg == OP_VSPAN)
        begin
            base_addr = ADDR_W'(first_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(line_reg);
        end
        else
        begin
            base_addr = ADDR_W'(line_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(first_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            len_reg   <= span_length;
            color_reg <= color;
        end
        if (cmd.clip)
        begin
            first_reg <= first_next;
            line_reg  <= line_next;
            onscr_reg <= (clip_count != '0);
        end
        if (cmd.addr)
        begin
            addr_reg   <= base_addr;
            stride_reg <= (op_reg == OP_VSPAN) ? ADDR_W'(SCREEN_WIDTH) : ADDR_W'(1);
        end
        else if (cmd.write)
        begin
            addr_reg <= addr_reg + stride_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg  <= '0;
            rem_reg <= '0;
            rd_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_reg <= '0;
            end
            if (cmd.clip)
            begin
                wc_reg  <= (op_reg == OP_READ) ? '0 : clip_count;
                rem_reg <= (op_reg == OP_READ) ? '0 : clip_count;
            end
            else if (cmd.write)
            begin
                rem_reg <= rem_reg - CNT_W'(1);
            end
            if (cmd.rd_cap)
            begin
                rd_reg <= onscr_reg ? ram_rdata : '0;
            end
        end
    end

    fcd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXEL_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (cmd.write),
        .re    (cmd.rd_req),
        .addr  (addr_reg),
        .wdata (color_reg),
        .rdata (ram_rdata)
    );

    assign stat.is_read     = (op_reg == OP_READ);
    assign stat.remain_zero = (rem_reg == '0);

    assign read_color    = rd_reg;
    assign written_count = wc_reg;

endmodule

[hw/rtl/framebuffer_clipped_draw.sv]
// RGB565 frame store of 320 x 240 pixels taking one drawing command at a time.
// A command is taken when start is high while busy is low; busy then stays high
// until the result word has been shown. The result (read_color, written_count)
// is on its ports for exactly one cycle with done high, and the receiver cannot
// stall it, so it must take it in that cycle. The store has a single port that
// writes one pixel per cycle, and that sets the time: a pixel, span or fill
// command passes the clip and address states and then writes its pixels before
// done, and a read passes the clip, address, read request and capture states.
// A new command may be started in the cycle after done. Pixels never written
// read back undefined.
module framebuffer_clipped_draw
    import fcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       opcode,
    input  logic signed [15:0]    pos_x,
    input  logic signed [15:0]    pos_y,
    input  logic signed [15:0]    span_length,
    input  logic [COLOR_W-1:0]    color,
    output logic                  done,
    output logic [COLOR_W-1:0]    read_color,
    output logic [CNT_W-1:0]      written_count
);

    fcd_cmd_t  cmd;
    fcd_stat_t stat;

    fcd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fcd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .span_length   (span_length),
        .color         (color),
        .read_color    (read_color),
        .written_count (written_count)
    );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fcd_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MAX_FILLS   = 4;
    localparam int RAND_PER_PHASE = 250;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] len;
        logic [COLOR_W-1:0] color;
        bit                 drain;
    } draw_cmd_t;

    typedef struct {
        logic [COLOR_W-1:0] read_color;
        logic [CNT_W-1:0]   written_count;
    } draw_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       opcode = '0;
    logic signed [15:0]    pos_x = '0;
    logic signed [15:0]    pos_y = '0;
    logic signed [15:0]    span_length = '0;
    logic [COLOR_W-1:0]    color = '0;
    logic                  done;
    logic [COLOR_W-1:0]    read_color;
    logic [CNT_W-1:0]      written_count;

    draw_cmd_t    draw_cmd_q[$];
    draw_result_t draw_results_q[$];
    draw_cmd_t    cmd_on_ports;
    logic [COLOR_W-1:0] shadow_frame [0:PIXEL_COUNT-1];

    int issued_cnt = 0;
    int seen_cnt = 0;
    int errors = 0;
    int idle_pct = 0;
    int cycles = 0;
    int fills_queued = 0;

    framebuffer_clipped_draw dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .span_length   (span_length),
        .color         (color),
        .done          (done),
        .read_color    (read_color),
        .written_count (written_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // clip a span to [0, lim), returning the covered length
    function automatic int clip_len(input int from, input int len, input int lim,
                                    output int first);
        first = 0;
        if (len <= 0)
            return 0;
        if (from < 0)
        begin
            len = len + from;
            from = 0;
        end
        if (from + len > lim)
            len = lim - from;
        first = from;
        return (len > 0) ? len : 0;
    endfunction

    // updates the shadow frame and queues the expected result word
    task automatic predict_draw(input draw_cmd_t c);
        int x;
        int y;
        int n;
        int first;
        draw_result_t r;
        bit on_screen;
        x = int'(c.x);
        y = int'(c.y);
        n = 0;
        first = 0;
        r.read_color = '0;
        on_screen = (x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT);
        case (c.op)
            OP_PIXEL:
                if (on_screen)
                begin
                    shadow_frame[y * SCREEN_WIDTH + x] = c.color;
                    n = 1;
                end
            OP_HSPAN:
                if (y >= 0 && y < SCREEN_HEIGHT)
                begin
                    n = clip_len(x, int'(c.len), SCREEN_WIDTH, first);
                    for (int i = 0; i < n; i++)
                        shadow_frame[y * SCREEN_WIDTH + first + i] = c.color;
                end
            OP_VSPAN:
                if (x >= 0 && x < SCREEN_WIDTH)
                begin
                    n = clip_len(y, int'(c.len), SCREEN_HEIGHT, first);
                    for (int i = 0; i < n; i++)
                        shadow_frame[(first + i) * SCREEN_WIDTH + x] = c.color;
                end
            OP_FILL:
            begin
                for (int i = 0; i < PIXEL_COUNT; i++)
                    shadow_frame[i] = c.color;
                n = PIXEL_COUNT;
            end
            OP_READ:
                if (on_screen)
                    r.read_color = shadow_frame[y * SCREEN_WIDTH + x];
            default:
                n = 0;
        endcase
        r.written_count = n[CNT_W-1:0];
        draw_results_q.push_back(r);
    endtask

    task automatic queue_draw(input logic [OP_W-1:0] op, input int x, input int y,
                              input int len, input logic [COLOR_W-1:0] c, input bit drain);
        draw_cmd_t w;
        w.op = op;
        w.x = x[15:0];
        w.y = y[15:0];
        w.len = len[15:0];
        w.color = c;
        w.drain = drain;
        draw_cmd_q.push_back(w);
    endtask

    // mostly near the screen, sometimes anywhere in the 16-bit range
    function automatic logic signed [15:0] rand_coord(input int lim);
        int v;
        if ($urandom_range(0, 99) < 70)
            v = int'($urandom_range(0, lim + 39)) - 20;
        else
            v = int'($urandom);
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] rand_len();
        int v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            v = $urandom_range(1, 64);
        else if (pick < 70)
            v = int'($urandom_range(0, 6)) - 5;
        else if (pick < 85)
            v = $urandom_range(1, 400);
        else
            v = int'($urandom);
        return v[15:0];
    endfunction

    task automatic queue_random(input bit drain);
        draw_cmd_t w;
        int pick;
        pick = $urandom_range(0, 999);
        w.x = rand_coord(SCREEN_WIDTH);
        w.y = rand_coord(SCREEN_HEIGHT);
        w.len = rand_len();
        w.color = COLOR_W'($urandom);
        w.drain = drain || ($urandom_range(0, 99) < 2);
        if (pick < 4 && fills_queued < MAX_FILLS)
        begin
            w.op = OP_FILL;
            fills_queued++;
        end
        else if (pick < 250)
            w.op = OP_PIXEL;
        else if (pick < 450)
            w.op = OP_HSPAN;
        else if (pick < 650)
            w.op = OP_VSPAN;
        else if (pick < 950)
            w.op = OP_READ;
        else
            w.op = OP_W'($urandom_range(int'(OP_READ) + 1, (1 << OP_W) - 1));
        draw_cmd_q.push_back(w);
    endtask

    // driver: a word is taken at an edge with start high and busy low
    always @(posedge clk)
    begin
        bit taken;
        bit offer;
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                predict_draw(cmd_on_ports);
                issued_cnt <= issued_cnt + 1;
            end
            if (taken || !start)
            begin
                offer = draw_cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct;
                if (offer && draw_cmd_q[0].drain && (taken || issued_cnt != seen_cnt))
                    offer = 1'b0;
                if (offer)
                begin
                    cmd_on_ports = draw_cmd_q.pop_front();
                    start <= 1'b1;
                    opcode <= cmd_on_ports.op;
                    pos_x <= cmd_on_ports.x;
                    pos_y <= cmd_on_ports.y;
                    span_length <= cmd_on_ports.len;
                    color <= cmd_on_ports.color;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: the result word is valid for the single cycle that done is high
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && done)
        begin
            if (draw_results_q.size() == 0)
            begin
                $display("%0t: unexpected word read_color=%h written_count=%0d",
                         $time, read_color, written_count);
                errors++;
            end
            else
            begin
                want = draw_results_q.pop_front();
                if (read_color !== want.read_color)
                begin
                    $display("%0t: read_color expected %h actual %h",
                             $time, want.read_color, read_color);
                    errors++;
                end
                if (written_count !== want.written_count)
                begin
                    $display("%0t: written_count expected %0d actual %0d",
                             $time, want.written_count, written_count);
                    errors++;
                end
            end
            seen_cnt <= seen_cnt + 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** framebuffer_clipped_draw: FAILED **");
            $finish;
        end
    end

    initial
    begin
        // whole screen written first so no read ever hits an unwritten pixel
        queue_draw(OP_FILL, 0, 0, 0, 16'h5aa5, 1'b0);
        queue_draw(OP_PIXEL, 0, 0, 0, 16'hffff, 1'b0);
        queue_draw(OP_PIXEL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 16'h0000, 1'b0);
        queue_draw(OP_PIXEL, SCREEN_WIDTH, 0, 0, 16'h1234, 1'b0);
        queue_draw(OP_PIXEL, -1, 5, 0, 16'h4321, 1'b0);
        queue_draw(OP_PIXEL, 32767, -32768, 0, 16'hffff, 1'b0);
        queue_draw(OP_READ, 0, 0, 0, 16'h0000, 1'b0);
        queue_draw(OP_READ, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 16'hffff, 1'b0);
        queue_draw(OP_READ, -1, 0, 0, 16'h0000, 1'b0);
        queue_draw(OP_READ, 0, SCREEN_HEIGHT, 0, 16'h0000, 1'b0);
        queue_draw(OP_HSPAN, -5, 10, 20, 16'h07e0, 1'b0);
        queue_draw(OP_HSPAN, SCREEN_WIDTH - 20, 11, 100, 16'hf800, 1'b0);
        queue_draw(OP_HSPAN, SCREEN_WIDTH, 12, 5, 16'h001f, 1'b0);
        queue_draw(OP_HSPAN, 3, 13, 0, 16'hffff, 1'b0);
        queue_draw(OP_HSPAN, 3, 14, -32768, 16'hffff, 1'b0);
        queue_draw(OP_HSPAN, 0, -1, 50, 16'hffff, 1'b0);
        queue_draw(OP_HSPAN, -32768, 15, 32767, 16'hffff, 1'b0);
        queue_draw(OP_HSPAN, 0, SCREEN_HEIGHT - 1, 32767, 16'h8001, 1'b0);
        queue_draw(OP_VSPAN, 5, -3, 10, 16'h7bef, 1'b0);
        queue_draw(OP_VSPAN, 6, SCREEN_HEIGHT - 40, 100, 16'hc618, 1'b0);
        queue_draw(OP_VSPAN, SCREEN_WIDTH, 0, 10, 16'hffff, 1'b0);
        queue_draw(OP_VSPAN, 0, 0, 32767, 16'h39e7, 1'b0);
        queue_draw(OP_READ + 3'd1, 100, 100, 10, 16'hffff, 1'b0);
        queue_draw({OP_W{1'b1}}, -1, -1, -1, 16'hffff, 1'b0);
        queue_draw(OP_READ, 6, SCREEN_HEIGHT - 1, 0, 16'h0000, 1'b1);
        fills_queued = 1;
        for (int i = 0; i < RAND_PER_PHASE; i++)
            queue_random(1'b0);
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 1; phase < 3; phase++)
        begin
            wait (draw_cmd_q.size() == 0);
            @(negedge clk);
            idle_pct = (phase == 1) ? 78 : 9;
            for (int i = 0; i < RAND_PER_PHASE; i++)
                queue_random(i == 0);
        end

        while (draw_cmd_q.size() != 0 || start || issued_cnt != seen_cnt)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (draw_results_q.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, draw_results_q.size());
            errors++;
        end
        if (errors == 0)
            $display("** framebuffer_clipped_draw: PASSED **");
        else
            $display("** framebuffer_clipped_draw: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fcd_pkg.sv
hw/rtl/fcd_ram.sv
hw/rtl/fcd_ctrl.sv
hw/rtl/fcd_dp.sv
hw/rtl/framebuffer_clipped_draw.sv
bench/tb.sv
